FILE: hdl/vssc_pkg.sv
`default_nettype none
package vssc_pkg;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN = 24;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [14:0] FULL_Q15 = 15'd32767;
    localparam logic [14:0] HALF_Q15 = 15'd16384;
    localparam logic [15:0] MIN_STEER_SPEED = 16'd26;

    localparam logic [1:0] OP_DESIRED = 2'd0;
    localparam logic [1:0] OP_MEASURED = 2'd1;
    localparam logic [1:0] OP_GO = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [1:0] MODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_AWAIT = 2'd1;
    localparam logic [1:0] MODE_TRACK = 2'd2;

    localparam logic [2:0] REG_WHEELBASE = 3'd0;
    localparam logic [2:0] REG_STEER_LIMIT = 3'd1;
    localparam logic [2:0] REG_ACCEL_LIMIT = 3'd2;
    localparam logic [2:0] REG_SPEED_LIMIT = 3'd3;
    localparam logic [2:0] REG_THROTTLE_GAIN = 3'd4;
    localparam logic [2:0] REG_BRAKE_GAIN = 3'd5;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // latch tick operands, set up cordic
        logic cordic;    // one cordic step
        logic div1_init; // start drive divide
        logic div2_init; // start steering divide
        logic div_step;  // one restoring divide step
        logic round;     // round and clamp angle
        logic finish;    // form result
    } dp_cmd_t;

    typedef struct packed {
        logic steer_needed;
    } dp_stat_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0: r = 32'h3243F6A8;  5'd1: r = 32'h1DAC6705;
            5'd2: r = 32'h0FADBAFC;  5'd3: r = 32'h07F56EA6;
            5'd4: r = 32'h03FEAB76;  5'd5: r = 32'h01FFD55B;
            5'd6: r = 32'h00FFFAAA;  5'd7: r = 32'h007FFF55;
            5'd8: r = 32'h003FFFEA;  5'd9: r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF; 5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF; 5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF; 5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF; 5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF; 5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF; 5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF; 5'd23: r = 32'h0000007F;
            default: r = 32'h0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/vssc_datapath.sv
`default_nettype none
module vssc_datapath (
    input  wire               aclk,
    input  wire vssc_pkg::dp_cmd_t cmd,
    input  wire [4:0]         step,
    input  wire [15:0]        wheelbase,
    input  wire [14:0]        steer_limit,
    input  wire [15:0]        accel_limit,
    input  wire [14:0]        speed_limit,
    input  wire [15:0]        throttle_gain,
    input  wire [15:0]        brake_gain,
    input  wire signed [15:0] measured_speed,
    input  wire signed [15:0] desired_speed,
    input  wire signed [15:0] desired_turn_rate,
    output vssc_pkg::dp_stat_t stat,
    output logic [14:0]       thr_out,
    output logic [14:0]       brk_out,
    output logic signed [15:0] steer_out
);
    // cordic values: y up to 2^31, grows by ~1.65 -> 38 bits signed is safe
    localparam int CW = 38;

    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [33:0]   z_reg;
    logic                 err_neg_reg;
    logic                 steer_ok_reg;
    logic signed [16:0]   ang_reg;      // rounded clamped Q2.14
    // shared restoring divider: 40-bit dividend, 16-bit divisor
    logic [39:0]          quo_reg;
    logic [16:0]          rem_reg;
    logic [15:0]          dvs_reg;
    logic                 dzero_reg;
    logic                 dnz_reg;
    logic [14:0]          drive_reg;

    // target clamp
    logic signed [16:0] lim_s, tgt;
    logic signed [17:0] err;          // clamped target minus measured, up to +-65535
    logic [16:0]        mag;
    logic [16:0]        tmag;
    logic [15:0]        gain;
    logic [39:0]        num;
    logic signed [31:0] yprod;
    logic signed [CW-1:0] x0, y0, xs, ys, dx, dy;
    logic signed [33:0] z0;
    logic [4:0]         sidx;
    logic [16:0]        rem_try;
    logic [33:0]        rnd;
    logic signed [17:0] rang;
    logic [15:0]        amag;
    logic [14:0]        sat_q;

    always_comb begin
        lim_s = {2'b00, speed_limit};
        tgt = 17'(desired_speed);
        if (tgt > lim_s) tgt = lim_s;
        if (tgt < -lim_s) tgt = -lim_s;
        err = 18'(tgt) - 18'(measured_speed);
        mag = err[17] ? 17'(-err) : 17'(err);
        tmag = tgt[16] ? 17'(-tgt) : tgt;
        gain = err[17] ? brake_gain : throttle_gain;
        num = {7'd0, 33'(gain * mag)} << 7;
        yprod = $signed({1'b0, wheelbase}) * desired_turn_rate;
        x0 = CW'(tgt) <<< 12;
        y0 = CW'(yprod);
        z0 = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                xs = y0; ys = -x0; z0 = 34'(vssc_pkg::HALF_PI_Q30);
            end else begin
                xs = -y0; ys = x0; z0 = -34'(vssc_pkg::HALF_PI_Q30);
            end
        end else begin
            xs = x0; ys = y0;
        end
        sidx = step;
        dx = y_reg >>> sidx;
        dy = x_reg >>> sidx;
        rem_try = {rem_reg[15:0], quo_reg[39]};
        rnd = 34'(z_reg + 34'sd32768);
        rang = 18'($signed(rnd) >>> 16);
        if (rang > $signed({3'b000, steer_limit})) rang = {3'b000, steer_limit};
        if (rang < -$signed({3'b000, steer_limit})) rang = -$signed({3'b000, steer_limit});
        amag = ang_reg[16] ? 16'(-ang_reg) : 16'(ang_reg);
        sat_q = (quo_reg > 40'(vssc_pkg::FULL_Q15)) ? vssc_pkg::FULL_Q15 : quo_reg[14:0];
        stat.steer_needed = steer_ok_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= xs;
            y_reg <= ys;
            z_reg <= z0;
            err_neg_reg <= err[17];
            steer_ok_reg <= (tmag >= 17'(vssc_pkg::MIN_STEER_SPEED)) && (steer_limit != 0);
        end
        if (cmd.cordic) begin
            if (y_reg > 0) begin
                x_reg <= x_reg + dx; y_reg <= y_reg - dy;
                z_reg <= z_reg + 34'(vssc_pkg::atan_q30(sidx));
            end else begin
                x_reg <= x_reg - dx; y_reg <= y_reg + dy;
                z_reg <= z_reg - 34'(vssc_pkg::atan_q30(sidx));
            end
        end
        if (cmd.round) ang_reg <= 17'(rang);
        if (cmd.div1_init) begin
            quo_reg <= num; rem_reg <= '0; dvs_reg <= accel_limit;
            dzero_reg <= (accel_limit == 0); dnz_reg <= (num != 0);
        end
        if (cmd.div2_init) begin
            drive_reg <= dzero_reg ? (dnz_reg ? vssc_pkg::FULL_Q15 : 15'd0) : sat_q;
            quo_reg <= {9'd0, amag, 15'd0}; rem_reg <= '0;
            dvs_reg <= {1'b0, steer_limit}; dzero_reg <= 1'b0;
        end
        if (cmd.div_step) begin
            if (rem_try >= {1'b0, dvs_reg}) begin
                rem_reg <= rem_try - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[38:0], 1'b1};
            end else begin
                rem_reg <= rem_try;
                quo_reg <= {quo_reg[38:0], 1'b0};
            end
        end
        if (cmd.finish) begin
            thr_out <= err_neg_reg ? 15'd0 : drive_reg;
            brk_out <= err_neg_reg ? drive_reg : 15'd0;
            if (!steer_ok_reg) steer_out <= '0;
            else steer_out <= ang_reg[16] ? -$signed({1'b0, sat_q}) : $signed({1'b0, sat_q});
        end
    end
endmodule
`default_nettype wire

FILE: hdl/vssc_ctrl.sv
`default_nettype none
module vssc_ctrl #(
    parameter int CORDIC_STEPS = vssc_pkg::CORDIC_STEPS_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        start,
    input  wire        track,
    input  wire vssc_pkg::dp_stat_t stat,
    output vssc_pkg::dp_cmd_t cmd,
    output logic [4:0] step,
    output logic       done
);
    localparam int NSTEP = (CORDIC_STEPS < vssc_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                                : vssc_pkg::TABLE_LEN;
    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_DIV1, S_ROUND, S_DIV2, S_FIN, S_OUT
    } state_t;
    state_t state_reg;
    logic [5:0] cnt_reg;

    assign step = cnt_reg[4:0];

    always_comb begin
        cmd = '0;
        done = 1'b0;
        case (state_reg)
            S_IDLE:   cmd.load = start & track;
            S_CORDIC: cmd.cordic = 1'b1;
            S_DIV1:   begin
                cmd.div1_init = (cnt_reg == 6'd0);
                cmd.div_step = (cnt_reg != 6'd0);
            end
            S_ROUND:  cmd.round = 1'b1;
            S_DIV2:   begin
                cmd.div2_init = (cnt_reg == 6'd0);
                cmd.div_step = (cnt_reg != 6'd0);
            end
            S_FIN:    cmd.finish = 1'b1;
            // datapath outputs are registered by now
            S_OUT:    done = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: if (start && track) begin
                    state_reg <= S_CORDIC; cnt_reg <= '0;
                end
                S_CORDIC: if (cnt_reg == 6'(NSTEP - 1)) begin
                    state_reg <= S_DIV1; cnt_reg <= '0;
                end else cnt_reg <= cnt_reg + 6'd1;
                S_DIV1: if (cnt_reg == 6'd40) begin
                    state_reg <= S_ROUND; cnt_reg <= '0;
                end else cnt_reg <= cnt_reg + 6'd1;
                S_ROUND: state_reg <= S_DIV2;
                S_DIV2: if (cnt_reg == 6'd40) begin
                    state_reg <= S_FIN; cnt_reg <= '0;
                end else cnt_reg <= cnt_reg + 6'd1;
                S_FIN: state_reg <= S_OUT;
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_fin_from_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIN |-> $past(state_reg) == S_DIV2) else $error("fin order");
    a_round_one: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ROUND |=> state_reg == S_DIV2) else $error("round");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 6'd40) else $error("cnt");
    a_steer_known: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIN |-> !$isunknown(stat.steer_needed)) else $error("stat");
endmodule
`default_nettype wire

FILE: hdl/vehicle_speed_steer_controller_core.sv
`default_nettype none
// Speed and steering controller. Input transactions carry an opcode on
// s_tuser (desired command, measured speed, go decision, control tick); only
// a tick yields an output transaction with throttle, brake, steering and drive
// mode. Non-tick transactions update state at the accepting edge and can
// follow back to back. A tick while stopped or before the first desired
// command has its result registered at the accepting edge. A tracking tick
// runs the CORDIC vectoring steps (CORDIC_STEPS capped at 24), one per cycle,
// then the drive divide, rounding of the angle, the steering divide, and
// forming and storing of the result; the two 40-step restoring divides share
// one divider. No input is accepted while a tracking tick is in progress.
// A waiting result holds off the input until it is taken.
// Config writes must happen while the block is idle.
module vehicle_speed_steer_controller_core #(
    parameter int CORDIC_STEPS = vssc_pkg::CORDIC_STEPS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // speed_value[15:0], turn_rate[31:16], go_flag[32]
    input  wire  [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // throttle[14:0], brake[29:15], steering[45:30], drive_mode[47:46]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    logic [15:0] wheelbase_reg, accel_limit_reg, throttle_gain_reg, brake_gain_reg;
    logic [14:0] steer_limit_reg, speed_limit_reg;
    logic signed [15:0] meas_reg, des_reg, turn_reg;
    logic cmd_seen_reg, go_reg;
    logic busy_reg;
    logic [47:0] out_reg;
    logic ovalid_reg;

    logic [1:0] op;
    logic acc, tick, track, done;
    vssc_pkg::dp_cmd_t cmd;
    vssc_pkg::dp_stat_t stat;
    logic [4:0] step;
    logic [14:0] thr, brk;
    logic signed [15:0] steer;

    assign op = s_tuser;
    assign s_tready = !busy_reg && !ovalid_reg;
    assign acc = s_tvalid && s_tready;
    assign tick = acc && (op == vssc_pkg::OP_TICK);
    assign track = go_reg && cmd_seen_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid = ovalid_reg;
    assign m_tdata = out_reg;

    vssc_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(tick), .track(track),
        .stat(stat), .cmd(cmd), .step(step), .done(done)
    );

    vssc_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .step(step),
        .wheelbase(wheelbase_reg), .steer_limit(steer_limit_reg),
        .accel_limit(accel_limit_reg), .speed_limit(speed_limit_reg),
        .throttle_gain(throttle_gain_reg), .brake_gain(brake_gain_reg),
        .measured_speed(meas_reg), .desired_speed(des_reg),
        .desired_turn_rate(turn_reg), .stat(stat),
        .thr_out(thr), .brk_out(brk), .steer_out(steer)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheelbase_reg <= 16'd256; steer_limit_reg <= 15'd5719;
            accel_limit_reg <= 16'd484; speed_limit_reg <= 15'd2176;
            throttle_gain_reg <= 16'd256; brake_gain_reg <= 16'd256;
            meas_reg <= '0; des_reg <= '0; turn_reg <= '0;
            cmd_seen_reg <= 1'b0; go_reg <= 1'b1;
            busy_reg <= 1'b0; ovalid_reg <= 1'b0;
            out_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    vssc_pkg::REG_WHEELBASE:     wheelbase_reg <= cfg_data;
                    vssc_pkg::REG_STEER_LIMIT:   steer_limit_reg <= cfg_data[14:0];
                    vssc_pkg::REG_ACCEL_LIMIT:   accel_limit_reg <= cfg_data;
                    vssc_pkg::REG_SPEED_LIMIT:   speed_limit_reg <= cfg_data[14:0];
                    vssc_pkg::REG_THROTTLE_GAIN: throttle_gain_reg <= cfg_data;
                    vssc_pkg::REG_BRAKE_GAIN:    brake_gain_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) ovalid_reg <= 1'b0;
            if (acc) begin
                case (op)
                    vssc_pkg::OP_DESIRED: begin
                        des_reg <= s_tdata[15:0]; turn_reg <= s_tdata[31:16];
                        cmd_seen_reg <= 1'b1;
                    end
                    vssc_pkg::OP_MEASURED: meas_reg <= s_tdata[15:0];
                    vssc_pkg::OP_GO: go_reg <= s_tdata[32];
                    vssc_pkg::OP_TICK: begin
                        if (!go_reg) begin
                            out_reg <= {vssc_pkg::MODE_STOPPED, 16'd0,
                                        vssc_pkg::FULL_Q15, 15'd0};
                            ovalid_reg <= 1'b1;
                        end else if (!cmd_seen_reg) begin
                            out_reg <= {vssc_pkg::MODE_AWAIT, 16'd0, 15'd0,
                                        vssc_pkg::HALF_Q15};
                            ovalid_reg <= 1'b1;
                        end else busy_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (done) begin
                out_reg <= {vssc_pkg::MODE_TRACK, steer, brk, thr};
                ovalid_reg <= 1'b1;
                busy_reg <= 1'b0;
            end
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready) else $error("accept while busy");
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> busy_reg) else $error("done idle");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
endmodule
`default_nettype wire
